// ----- design/mtsed_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-touch slot event decoder package
// Event codes, internal operation codes and the queue item type.
// ----------------------------------------------------------------------------
package mtsed_pkg;

	localparam logic [15:0] TYPE_SYN    = 16'h0000;
	localparam logic [15:0] TYPE_ABS    = 16'h0003;
	localparam logic [15:0] CODE_REPORT = 16'h0000;
	localparam logic [15:0] CODE_SLOT   = 16'h002f;
	localparam logic [15:0] CODE_TRACK  = 16'h0039;
	localparam logic [15:0] CODE_POS_X  = 16'h0035;
	localparam logic [15:0] CODE_POS_Y  = 16'h0036;

	localparam int          COORD_W   = 12;
	localparam logic [11:0] COORD_MAX = 12'hfff;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_PRESS   = 2'd1,
		KIND_MOVE    = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_SLOT,
		OP_RELEASE,
		OP_PRESS,
		OP_POS_X,
		OP_POS_Y,
		OP_FLUSH
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] arg;
	} item_t;

endpackage

// ----- design/mtsed_front.sv -----
// ----------------------------------------------------------------------------
// Multi-touch front end
// Classifies each input event into an operation and pushes it to the queue unless it is a no-op.
// ----------------------------------------------------------------------------
module mtsed_front #(
	parameter int SLOTS = 5
) (
	input  logic               ev_valid,
	output logic               ev_stall,
	input  logic [15:0]        ev_type,
	input  logic [15:0]        ev_code,
	input  logic [31:0]        ev_value,
	output logic               push,
	output mtsed_pkg::item_t   push_item,
	input  logic               q_full
);
	import mtsed_pkg::*;

	logic               slot_ok;
	logic [COORD_W-1:0] coord;
	op_t                op;

	assign slot_ok = !ev_value[31] && (ev_value[30:0] < 31'(SLOTS));

	always_comb begin
		if (ev_value[31]) begin
			coord = '0;
		end else if (|ev_value[30:COORD_W]) begin
			coord = COORD_MAX;
		end else begin
			coord = ev_value[COORD_W-1:0];
		end
	end

	always_comb begin
		op = OP_NOP;
		if (ev_type == TYPE_ABS) begin
			case (ev_code)
				CODE_SLOT:  op = slot_ok ? OP_SLOT : OP_NOP;
				CODE_TRACK: op = (ev_value == 32'hffff_ffff) ? OP_RELEASE : OP_PRESS;
				CODE_POS_X: op = OP_POS_X;
				CODE_POS_Y: op = OP_POS_Y;
				default:    op = OP_NOP;
			endcase
		end else if (ev_type == TYPE_SYN && ev_code == CODE_REPORT) begin
			op = OP_FLUSH;
		end
	end

	assign ev_stall      = q_full;
	assign push          = ev_valid && !q_full && (op != OP_NOP);
	assign push_item.op  = op;
	assign push_item.arg = (op == OP_SLOT) ? ev_value[COORD_W-1:0] : coord;

endmodule

// ----- design/mtsed_queue.sv -----
// ----------------------------------------------------------------------------
// Multi-touch operation queue
// Two-entry queue between the front end and the slot state engine.
// ----------------------------------------------------------------------------
module mtsed_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mtsed_pkg::item_t push_item,
	output logic             full,
	output logic             q_valid,
	input  logic             pop,
	output mtsed_pkg::item_t pop_item
);
	import mtsed_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/mtsed_back.sv -----
// ----------------------------------------------------------------------------
// Multi-touch slot state engine
// Holds the per-slot state, carries out one operation per cycle unless a held
// report is stalled, and registers the touch report.
// ----------------------------------------------------------------------------
module mtsed_back #(
	parameter int SLOTS = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             pop,
	input  mtsed_pkg::item_t pop_item,
	output logic             rpt_valid,
	input  logic             rpt_stall,
	output logic [1:0]       touch_kind,
	output logic [11:0]      pos_x,
	output logic [11:0]      pos_y,
	output logic [2:0]       finger_index
);
	import mtsed_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOT_W-1:0]  cur_q;
	logic [COORD_W-1:0] pos_x_q [SLOTS];
	logic [COORD_W-1:0] pos_y_q [SLOTS];
	kind_t              pend_q  [SLOTS];

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [SLOT_W-1:0]  out_slot_q;

	kind_t pend_cur;
	logic  emit;
	kind_t emit_kind;

	assign pop      = q_valid && (!out_valid_q || !rpt_stall);
	assign pend_cur = pend_q[cur_q];

	always_comb begin
		emit      = 1'b0;
		emit_kind = pend_cur;
		case (pop_item.op)
			OP_SLOT, OP_FLUSH: emit = (pend_cur != KIND_NONE);
			OP_RELEASE: begin
				emit      = 1'b1;
				emit_kind = KIND_RELEASE;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_NONE;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_slot_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				pos_x_q[i] <= '0;
				pos_y_q[i] <= '0;
				pend_q[i]  <= KIND_NONE;
			end
		end else begin
			if (pop) begin
				out_valid_q <= emit;
				if (emit) begin
					out_kind_q <= emit_kind;
					out_x_q    <= pos_x_q[cur_q];
					out_y_q    <= pos_y_q[cur_q];
					out_slot_q <= cur_q;
				end
				case (pop_item.op)
					OP_SLOT: begin
						cur_q         <= pop_item.arg[SLOT_W-1:0];
						pend_q[cur_q] <= KIND_NONE;
					end
					OP_FLUSH, OP_RELEASE: pend_q[cur_q] <= KIND_NONE;
					OP_PRESS: pend_q[cur_q] <= KIND_PRESS;
					OP_POS_X: begin
						pos_x_q[cur_q] <= pop_item.arg;
						if (pend_cur != KIND_PRESS) begin
							pend_q[cur_q] <= KIND_MOVE;
						end
					end
					OP_POS_Y: begin
						pos_y_q[cur_q] <= pop_item.arg;
						if (pend_cur != KIND_PRESS) begin
							pend_q[cur_q] <= KIND_MOVE;
						end
					end
					default: cur_q <= cur_q;
				endcase
			end else if (!rpt_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rpt_valid    = out_valid_q;
	assign touch_kind   = out_kind_q;
	assign pos_x        = out_x_q;
	assign pos_y        = out_y_q;
	assign finger_index = 3'(out_slot_q);

endmodule

// ----- design/multitouch_slot_event_decoder.sv -----
// ----------------------------------------------------------------------------
// Multi-touch slot event decoder
// Decodes protocol B input events into press, move and release reports.
//
// Channel   Handshake             Payload
// event     ev_valid / ev_stall   ev_type, ev_code, ev_value
// report    rpt_valid / rpt_stall touch_kind, pos_x, pos_y, finger_index
//
// One event is taken every cycle while ev_stall is low; the combinational
// classifier feeds the queue, and the state engine registers the report.
// Reset clears the current slot, all coordinates and all pending events.
// A stalled report holds the state engine, and the two-entry queue then
// fills and stalls the event channel.
// ----------------------------------------------------------------------------
module multitouch_slot_event_decoder #(
	parameter int SLOTS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_valid,
	output logic        ev_stall,
	input  logic [15:0] ev_type,
	input  logic [15:0] ev_code,
	input  logic [31:0] ev_value,
	output logic        rpt_valid,
	input  logic        rpt_stall,
	output logic [1:0]  touch_kind,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	output logic [2:0]  finger_index
);
	import mtsed_pkg::*;

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_valid;
	logic  pop;
	item_t pop_item;

	mtsed_front #(.SLOTS(SLOTS)) u_front (
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.ev_type   (ev_type),
		.ev_code   (ev_code),
		.ev_value  (ev_value),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	mtsed_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.q_valid   (q_valid),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	mtsed_back #(.SLOTS(SLOTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.pop          (pop),
		.pop_item     (pop_item),
		.rpt_valid    (rpt_valid),
		.rpt_stall    (rpt_stall),
		.touch_kind   (touch_kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.finger_index (finger_index)
	);

endmodule

// ----- verif/tb_multitouch_slot_event_decoder.sv -----
// ----------------------------------------------------------------------------
// Multi-touch slot event decoder testbench
// Drives protocol B events into the decoder with random gaps and report
// stalls. A table of directed events runs first, then a random stream that is
// mostly well-formed slot, tracking, position and report traffic. Every accepted
// event updates a local slot model, and each report is matched field by field
// against the oldest touch that the model expects.
// ----------------------------------------------------------------------------
module tb_multitouch_slot_event_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	import mtsed_pkg::*;

	localparam int SLOTS       = 5;
	localparam int RAND_EVENTS = 1025;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ROWS        = 25;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] x;
		logic [11:0] y;
		logic [2:0]  idx;
	} touch_t;

	typedef struct packed {
		logic [15:0] t;
		logic [15:0] c;
		logic [31:0] v;
		logic        fixed;
		logic        has;
		logic [1:0]  kind;
		logic [11:0] x;
		logic [11:0] y;
		logic [2:0]  idx;
	} ev_row_t;

	// Rows marked fixed carry the touch (or its absence) that they must cause.
	localparam ev_row_t SCRIPT [ROWS] = '{
		'{TYPE_SYN, CODE_REPORT, 32'd0,          1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_TRACK,  32'hffff_ffff,  1'b1, 1'b1, KIND_RELEASE, 12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_POS_X,  32'd5000,       1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_POS_Y,  32'hffff_fff9,  1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_SYN, CODE_REPORT, 32'd0,          1'b1, 1'b1, KIND_MOVE,    12'd4095, 12'd0,    3'd0},
		'{TYPE_ABS, CODE_TRACK,  32'd17,         1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_POS_X,  32'd100,        1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_POS_Y,  32'd4095,       1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_SLOT,   32'd4,          1'b1, 1'b1, KIND_PRESS,   12'd100,  12'd4095, 3'd0},
		'{TYPE_ABS, CODE_SLOT,   32'd5,          1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_SLOT,   32'hffff_ffff,  1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_SLOT,   32'h7fff_ffff,  1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_POS_X,  32'h8000_0000,  1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_POS_Y,  32'h7fff_ffff,  1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_SYN, 16'h0001,    32'd0,          1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{16'hffff, CODE_REPORT, 32'hffff_ffff,  1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, 16'hffff,    32'd0,          1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, 16'h0000,    32'd123,        1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_SYN, CODE_REPORT, 32'd0,          1'b1, 1'b1, KIND_MOVE,    12'd0,    12'd4095, 3'd4},
		'{TYPE_SYN, CODE_REPORT, 32'd0,          1'b1, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_TRACK,  32'd0,          1'b0, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_TRACK,  32'hffff_ffff,  1'b1, 1'b1, KIND_RELEASE, 12'd0,    12'd4095, 3'd4},
		'{TYPE_ABS, CODE_POS_X,  32'd4095,       1'b0, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0},
		'{TYPE_ABS, CODE_SLOT,   32'd4,          1'b1, 1'b1, KIND_MOVE,    12'd4095, 12'd4095, 3'd4},
		'{TYPE_ABS, CODE_SLOT,   32'd0,          1'b0, 1'b0, KIND_NONE,    12'd0,    12'd0,    3'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        ev_valid;
	logic        ev_stall;
	logic [15:0] ev_type;
	logic [15:0] ev_code;
	logic [31:0] ev_value;
	logic        rpt_valid;
	logic        rpt_stall;
	logic [1:0]  touch_kind;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [2:0]  finger_index;

	ev_row_t     drv_row;
	bit          burst;
	bit          draining;
	int          errors;
	int          cycle_count;
	touch_t      due_touches [$];

	logic [2:0]  slot_now;
	logic [11:0] slot_x [SLOTS];
	logic [11:0] slot_y [SLOTS];
	kind_t       slot_wait [SLOTS];

	multitouch_slot_event_decoder #(
		.SLOTS(SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_valid    (ev_valid),
		.ev_stall    (ev_stall),
		.ev_type     (ev_type),
		.ev_code     (ev_code),
		.ev_value    (ev_value),
		.rpt_valid   (rpt_valid),
		.rpt_stall   (rpt_stall),
		.touch_kind  (touch_kind),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.finger_index(finger_index)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic flag_error(input string msg);
		if (errors < 40) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
		errors++;
	endtask

	function automatic logic [11:0] sat_coord(input logic signed [31:0] v);
		if (v < 0) begin
			return 12'd0;
		end
		if (v > 4095) begin
			return COORD_MAX;
		end
		return v[11:0];
	endfunction

	function automatic bit take_pending(input logic [2:0] s, output touch_t r);
		r = '{slot_wait[s], slot_x[s], slot_y[s], s};
		take_pending = (slot_wait[s] != KIND_NONE);
		slot_wait[s] = KIND_NONE;
	endfunction

	function automatic bit decode_event(input logic [15:0] t, input logic [15:0] c,
			input logic signed [31:0] v, output touch_t r);
		logic [2:0] s;
		s = slot_now;
		r = '0;
		decode_event = 1'b0;
		if (t == TYPE_ABS) begin
			if (c == CODE_SLOT) begin
				if (v >= 0 && v < SLOTS) begin
					slot_now = v[2:0];
					decode_event = take_pending(s, r);
				end
			end else if (c == CODE_TRACK) begin
				if (v == -1) begin
					slot_wait[s] = KIND_NONE;
					r = '{KIND_RELEASE, slot_x[s], slot_y[s], s};
					decode_event = 1'b1;
				end else begin
					slot_wait[s] = KIND_PRESS;
				end
			end else if (c == CODE_POS_X || c == CODE_POS_Y) begin
				if (c == CODE_POS_X) begin
					slot_x[s] = sat_coord(v);
				end else begin
					slot_y[s] = sat_coord(v);
				end
				if (slot_wait[s] != KIND_PRESS) begin
					slot_wait[s] = KIND_MOVE;
				end
			end
		end else if (t == TYPE_SYN && c == CODE_REPORT) begin
			decode_event = take_pending(s, r);
		end
	endfunction

	task automatic offer_event(input ev_row_t row, input int gap);
		if (gap > 0) begin
			ev_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ev_valid <= 1'b1;
		ev_type  <= row.t;
		ev_code  <= row.c;
		ev_value <= row.v;
		drv_row  <= row;
		do @(posedge clk); while (!(ev_valid && !ev_stall));
		@(negedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		touch_t want;
		bit     has;
		if (arst_n && ev_valid && !ev_stall) begin
			has = decode_event(ev_type, ev_code, ev_value, want);
			if (drv_row.fixed) begin
				has  = drv_row.has;
				want = '{drv_row.kind, drv_row.x, drv_row.y, drv_row.idx};
			end
			if (has) begin
				due_touches.push_back(want);
			end
		end
		if (arst_n && rpt_valid && !rpt_stall) begin
			if (due_touches.size() == 0) begin
				flag_error("touch report arrived with none expected");
			end else begin
				want = due_touches.pop_front();
				if (touch_kind !== want.kind) begin
					flag_error($sformatf("touch_kind %0d, expected %0d", touch_kind, want.kind));
				end
				if (pos_x !== want.x) begin
					flag_error($sformatf("pos_x %0d, expected %0d", pos_x, want.x));
				end
				if (pos_y !== want.y) begin
					flag_error($sformatf("pos_y %0d, expected %0d", pos_y, want.y));
				end
				if (finger_index !== want.idx) begin
					flag_error($sformatf("finger_index %0d, expected %0d",
						finger_index, want.idx));
				end
			end
		end
	end

	initial begin : report_sink
		int  taken;
		int  hold;
		bit  held_long;
		taken = 0;
		held_long = 1'b0;
		rpt_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (burst && !held_long) begin
				held_long = 1'b1;
				hold = 80;
			end else if (draining || (taken / 120) % 3 == 2) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 14);
			end
			if (hold > 0) begin
				rpt_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rpt_stall <= 1'b0;
			do @(posedge clk); while (!(rpt_valid && !rpt_stall));
			taken++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		ev_row_t row;
		int      pick;
		int      gap;
		errors   = 0;
		burst    = 1'b0;
		draining = 1'b0;
		arst_n   = 1'b0;
		ev_valid = 1'b0;
		ev_type  = '0;
		ev_code  = '0;
		ev_value = '0;
		drv_row  = '0;
		slot_now = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_x[i]    = '0;
			slot_y[i]    = '0;
			slot_wait[i] = KIND_NONE;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < ROWS; i++) begin
			offer_event(SCRIPT[i], (i < 12) ? 0 : $urandom_range(0, 14));
		end

		for (int i = 0; i < RAND_EVENTS; i++) begin
			if (i == 300) begin
				burst = 1'b1;
			end
			if (i == 420) begin
				burst = 1'b0;
			end
			if (i == 700) begin
				// Let the decoder drain completely before going on.
				ev_valid <= 1'b0;
				while (due_touches.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			row = '0;
			row.t = TYPE_ABS;
			row.v = $urandom_range(0, 4095);
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				row.c = CODE_SLOT;
				case ($urandom_range(0, 7))
					0: row.v = $urandom;
					1: row.v = $urandom_range(SLOTS, 7);
					2: row.v = 32'hffff_ffff;
					default: row.v = $urandom_range(0, SLOTS - 1);
				endcase
			end else if (pick < 26) begin
				row.c = CODE_TRACK;
				row.v = ($urandom_range(0, 2) == 0) ? 32'hffff_ffff : $urandom;
			end else if (pick < 62) begin
				row.c = $urandom_range(0, 1) ? CODE_POS_X : CODE_POS_Y;
				if ($urandom_range(0, 7) == 0) begin
					row.v = $urandom;
				end
			end else if (pick < 86) begin
				row.t = TYPE_SYN;
				row.c = CODE_REPORT;
				row.v = $urandom;
			end else if (pick < 93) begin
				row.t = 16'($urandom);
				row.c = 16'($urandom);
				row.v = $urandom;
			end else begin
				row.t = $urandom_range(0, 1) ? TYPE_SYN : TYPE_ABS;
				row.c = 16'($urandom_range(0, 63));
				row.v = $urandom;
			end
			gap = (burst || (i / 150) % 3 == 1) ? 0 : $urandom_range(0, 14);
			offer_event(row, gap);
		end
		ev_valid <= 1'b0;
		draining = 1'b1;

		while (due_touches.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0 && due_touches.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
